// ===== hdl/msd_pkg.sv =====
// msd_pkg: shared types, constants and direction table of the move stream decoder.
// No dependencies.
package msd_pkg;

	localparam int INC_W = 28;

	localparam logic [1:0] SEL_TRIPLE = 2'd0;
	localparam logic [1:0] SEL_SHORT1 = 2'd1;
	localparam logic [1:0] SEL_SHORT2 = 2'd2;
	localparam logic [1:0] SEL_LONG   = 2'd3;

	localparam logic [31:0] TICK_RESTART = 32'hFFFF_FFFF;
	localparam logic [31:0] TRIPLE_STEP  = 32'd4;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_TRIPLE,
		OP_MOVE,
		OP_ERROR
	} op_t;

	typedef struct packed {
		op_t              op;
		logic             restart;
		logic [8:0]       dir;
		logic [INC_W-1:0] inc;
	} cmd_t;

	function automatic logic [8:0] dir_mask(input logic [2:0] idx);
		logic [8:0] m;
		case (idx)
			3'd0: m = 9'd1;
			3'd1: m = 9'd2;
			3'd2: m = 9'd4;
			3'd3: m = 9'd8;
			3'd4: m = 9'd3;
			3'd5: m = 9'd6;
			3'd6: m = 9'd9;
			3'd7: m = 9'd12;
			default: m = 9'd0;
		endcase
		return m;
	endfunction

endpackage

// ===== hdl/msd_front.sv =====
// msd_front: accepts stream bytes, gathers multi-byte values and classifies them into commands.
// Depends on msd_pkg.
module msd_front import msd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] data_byte,
	input  logic       first_byte,
	input  logic       last_byte,
	output logic       cmd_valid,
	output cmd_t       cmd
);

	logic [7:0] pend_q [4];
	logic [2:0] held_q, need_q;

	logic [2:0]  held_e, need_e, held_n, need_n, extra;
	logic        complete, pend_we;
	logic [1:0]  pend_idx;
	logic [7:0]  b0, v1, v2, v3, v4;
	logic [25:0] wide_d;
	logic [26:0] orth_d;
	logic [10:0] t2_d;
	logic [26:0] val_d;
	logic [8:0]  val_dir;

	assign held_e   = first_byte ? 3'd0 : held_q;
	assign need_e   = first_byte ? 3'd0 : need_q;
	assign complete = (held_e != 3'd0) &&
		((4'(held_e) + 4'd1 >= 4'(need_e)) || (held_e >= 3'd4));

	assign b0 = pend_q[0];
	assign v1 = (held_e == 3'd1) ? data_byte : pend_q[1];
	assign v2 = (held_e == 3'd2) ? data_byte : pend_q[2];
	assign v3 = (held_e == 3'd3) ? data_byte : pend_q[3];
	assign v4 = data_byte;
	assign extra = held_e - 3'd1;

	always_comb begin
		wide_d = {24'd0, v1[7:6]};
		if (extra > 3'd0)
			wide_d = wide_d | {16'd0, v2, 2'd0};
		if (extra > 3'd1)
			wide_d = wide_d | {8'd0, v3, 10'd0};
		if (extra > 3'd2)
			wide_d = wide_d | {v4, 18'd0};
	end

	assign orth_d = {v3, v2, v1, b0[7:5]};
	assign t2_d   = {v1, b0[7:5]};

	always_comb begin
		if (b0[1:0] == SEL_SHORT2) begin
			val_d   = 27'(t2_d);
			val_dir = dir_mask(b0[4:2]);
		end else if (b0[4]) begin
			val_d   = 27'(wide_d);
			val_dir = {v1[5:0], b0[7:5]};
		end else begin
			val_d   = orth_d;
			val_dir = dir_mask({1'b0, b0[3:2]});
		end
	end

	always_comb begin
		cmd_valid   = 1'b0;
		cmd.op      = OP_NONE;
		cmd.restart = first_byte;
		cmd.dir     = 9'd0;
		cmd.inc     = '0;
		held_n      = held_e;
		need_n      = need_e;
		pend_we     = 1'b0;
		pend_idx    = held_e[1:0];
		if (held_e == 3'd0) begin
			case (data_byte[1:0])
				SEL_TRIPLE: begin
					cmd_valid = 1'b1;
					cmd.op    = OP_TRIPLE;
					cmd.dir   = {1'b0, data_byte};
				end
				SEL_SHORT1: begin
					cmd_valid = 1'b1;
					cmd.op    = OP_MOVE;
					cmd.dir   = dir_mask(data_byte[4:2]);
					cmd.inc   = INC_W'(data_byte[7:5]) + INC_W'(1);
				end
				default: begin
					pend_we = 1'b1;
					if (data_byte[1:0] == SEL_SHORT2)
						need_n = 3'd2;
					else if (data_byte[4])
						need_n = 3'd2 + {1'b0, data_byte[3:2]};
					else
						need_n = 3'd4;
					held_n = 3'd1;
					if (last_byte) begin
						held_n    = 3'd0;
						need_n    = 3'd0;
						cmd_valid = 1'b1;
						cmd.op    = OP_ERROR;
					end else if (first_byte) begin
						cmd_valid = 1'b1;
						cmd.op    = OP_NONE;
					end
				end
			endcase
		end else if (complete) begin
			held_n    = 3'd0;
			need_n    = 3'd0;
			cmd_valid = 1'b1;
			cmd.op    = OP_MOVE;
			cmd.dir   = val_dir;
			cmd.inc   = INC_W'(val_d) + INC_W'(1);
		end else begin
			pend_we = 1'b1;
			held_n  = held_e + 3'd1;
			if (last_byte) begin
				held_n    = 3'd0;
				need_n    = 3'd0;
				cmd_valid = 1'b1;
				cmd.op    = OP_ERROR;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 3'd0;
			need_q <= 3'd0;
		end else if (accept) begin
			held_q <= held_n;
			need_q <= need_n;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && pend_we)
			pend_q[pend_idx] <= data_byte;
	end

endmodule

// ===== hdl/msd_queue.sv =====
// msd_queue: short command queue between the front and back parts.
// Depends on msd_pkg.
module msd_queue import msd_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cmd_t wr_cmd,
	output logic full,
	input  logic rd_en,
	output logic rd_valid,
	output cmd_t rd_cmd
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	cmd_t             slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_cmd   = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			if (rd_en)
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			if (wr_en && !rd_en)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (rd_en && !wr_en)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			slot_q[wr_ptr_q] <= wr_cmd;
	end

endmodule

// ===== hdl/msd_back.sv =====
// msd_back: executes queued commands, keeps the tick counter and drives the result register.
// Depends on msd_pkg.
module msd_back import msd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	input  cmd_t        cmd,
	output logic        cmd_pop,
	input  logic        pop,
	output logic        empty,
	output logic        kind,
	output logic [8:0]  move_dir,
	output logic [31:0] move_time,
	output logic        run_last
);

	logic [1:0]  sub_q, sub_n;
	logic [31:0] tick_q, tick_n, base;
	logic        out_v_q;
	logic        kind_q, last_q;
	logic [8:0]  dir_q;
	logic [31:0] time_q;

	logic        slot_free, emit, e_kind, e_last;
	logic [8:0]  e_dir;
	logic [31:0] e_time;
	logic [1:0]  tri_idx;

	assign slot_free = !out_v_q || pop;
	assign base = (cmd.restart && sub_q == 2'd0) ? TICK_RESTART : tick_q;

	always_comb begin
		case (sub_q)
			2'd0:    tri_idx = cmd.dir[3:2];
			2'd1:    tri_idx = cmd.dir[5:4];
			default: tri_idx = cmd.dir[7:6];
		endcase
	end

	always_comb begin
		cmd_pop = 1'b0;
		emit    = 1'b0;
		e_kind  = 1'b0;
		e_dir   = 9'd0;
		e_time  = 32'd0;
		e_last  = 1'b1;
		tick_n  = tick_q;
		sub_n   = sub_q;
		if (cmd_valid) begin
			case (cmd.op)
				OP_NONE: begin
					cmd_pop = 1'b1;
					tick_n  = TICK_RESTART;
				end
				OP_ERROR: begin
					if (slot_free) begin
						emit    = 1'b1;
						e_kind  = 1'b1;
						cmd_pop = 1'b1;
						tick_n  = base;
					end
				end
				OP_MOVE: begin
					if (slot_free) begin
						emit    = 1'b1;
						e_dir   = cmd.dir;
						e_time  = base + 32'(cmd.inc);
						tick_n  = e_time;
						cmd_pop = 1'b1;
					end
				end
				OP_TRIPLE: begin
					if (slot_free) begin
						emit   = 1'b1;
						e_dir  = dir_mask({1'b0, tri_idx});
						e_time = base + TRIPLE_STEP;
						tick_n = e_time;
						e_last = (sub_q == 2'd2);
						if (sub_q == 2'd2) begin
							cmd_pop = 1'b1;
							sub_n   = 2'd0;
						end else begin
							sub_n = sub_q + 2'd1;
						end
					end
				end
				default: begin
					cmd_pop = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q  <= TICK_RESTART;
			sub_q   <= 2'd0;
			out_v_q <= 1'b0;
		end else begin
			tick_q <= tick_n;
			sub_q  <= sub_n;
			if (emit)
				out_v_q <= 1'b1;
			else if (pop)
				out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q <= e_kind;
			dir_q  <= e_dir;
			time_q <= e_time;
			last_q <= e_last;
		end
	end

	assign empty     = !out_v_q;
	assign kind      = kind_q;
	assign move_dir  = dir_q;
	assign move_time = time_q;
	assign run_last  = last_q;

endmodule

// ===== hdl/move_stream_decoder_core.sv =====
// A command is queued at the edge that accepts its byte, and the result register loads from the queue
// head once the register is free. Throughput: one byte per cycle at the input while the queue is not
// full; the result register passes one move a cycle while popped; a triple byte gives three moves.
// The command queue (QUEUE_DEPTH entries) absorbs bursts between the two parts.
// Reset: asynchronous, active low; tick counter set to all ones, queue and partial value emptied.
// Depends on msd_pkg, msd_front, msd_queue, msd_back.
module move_stream_decoder_core import msd_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        first_byte,
	input  logic        last_byte,
	output logic        empty,
	input  logic        pop,
	output logic        kind,
	output logic [8:0]  move_dir,
	output logic [31:0] move_time,
	output logic        run_last
);

	logic in_acc, f_valid, q_push, q_full, q_valid, q_pop;
	cmd_t f_cmd, q_cmd;

	assign full   = q_full;
	assign in_acc = push && !q_full;
	assign q_push = in_acc && f_valid;

	msd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (in_acc),
		.data_byte  (data_byte),
		.first_byte (first_byte),
		.last_byte  (last_byte),
		.cmd_valid  (f_valid),
		.cmd        (f_cmd)
	);

	msd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (q_push),
		.wr_cmd   (f_cmd),
		.full     (q_full),
		.rd_en    (q_pop),
		.rd_valid (q_valid),
		.rd_cmd   (q_cmd)
	);

	msd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd       (q_cmd),
		.cmd_pop   (q_pop),
		.pop       (pop),
		.empty     (empty),
		.kind      (kind),
		.move_dir  (move_dir),
		.move_time (move_time),
		.run_last  (run_last)
	);

	a_err_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind) |-> (move_dir == 9'd0 && move_time == 32'd0 && run_last))
		else $error("error item with nonzero fields");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("command popped from empty queue");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("command pushed into full queue");

	a_out_known: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !$isunknown({kind, move_dir, move_time, run_last}))
		else $error("result item with unknown fields");

endmodule
